@@ rtl/core/hrp_pkg.sv @@
// Shared types and constants of the HTTP request header parser.
// Holds the transfer payload structs, the phase encoding and the token tables.
// No dependencies.
package hrp_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] byte_class;
        logic [3:0] method_code;
        logic       method_valid;
        logic [2:0] version_code;
        logic       version_valid;
        logic       pair_end;
        logic       header_error;
        logic       headers_done;
        logic       last_out;
    } t_out_item;

    // Per-byte control from the phase sequencer to the token matchers
    typedef struct packed {
        logic step;
        logic feed_method;
        logic feed_version;
        logic clear;
    } t_feed_ctl;

    typedef enum logic [12:0] {
        PH_METHOD  = 13'b0000000000001,
        PH_URI_GAP = 13'b0000000000010,
        PH_URI     = 13'b0000000000100,
        PH_VER_GAP = 13'b0000000001000,
        PH_VER     = 13'b0000000010000,
        PH_VER_LF  = 13'b0000000100000,
        PH_LINE    = 13'b0000001000000,
        PH_NAME    = 13'b0000010000000,
        PH_VAL_GAP = 13'b0000100000000,
        PH_VAL     = 13'b0001000000000,
        PH_LINE_LF = 13'b0010000000000,
        PH_END_LF  = 13'b0100000000000,
        PH_BODY    = 13'b1000000000000
    } t_phase;

    localparam logic [2:0] CL_METHOD  = 3'd0;
    localparam logic [2:0] CL_URI     = 3'd1;
    localparam logic [2:0] CL_VERSION = 3'd2;
    localparam logic [2:0] CL_NAME    = 3'd3;
    localparam logic [2:0] CL_VALUE   = 3'd4;
    localparam logic [2:0] CL_DELIM   = 3'd5;
    localparam logic [2:0] CL_BODY    = 3'd6;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [3:0] MC_UNKNOWN = 4'd8;
    localparam logic [2:0] VC_UNKNOWN = 3'd4;

    localparam int unsigned NUM_METHODS  = 8;
    localparam int unsigned NUM_VERSIONS = 4;
    localparam logic [3:0]  TOKEN_MAX    = 4'd15;
    localparam logic [3:0]  VERSION_LEN  = 4'd8;

    // Names are left-justified: character 0 sits in bits 63:56
    localparam logic [63:0] METHOD_NAME [NUM_METHODS] = '{
        {"GET",     40'd0},
        {"POST",    32'd0},
        {"OPTIONS",  8'd0},
        {"HEAD",    32'd0},
        {"PUT",     40'd0},
        {"DELETE",  16'd0},
        {"TRACE",   24'd0},
        {"CONNECT",  8'd0}
    };

    localparam logic [3:0] METHOD_LEN [NUM_METHODS] = '{
        4'd3, 4'd4, 4'd7, 4'd4, 4'd3, 4'd6, 4'd5, 4'd7
    };

    localparam logic [63:0] VERSION_NAME [NUM_VERSIONS] = '{
        "HTTP/0.9", "HTTP/1.0", "HTTP/1.1", "HTTP/2.0"
    };

endpackage

@@ rtl/core/hrp_token_match.sv @@
// Method and version token matchers: candidate masks and token lengths.
// Depends on hrp_pkg for the name tables and the feed control struct.
module hrp_token_match (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hrp_pkg::t_feed_ctl i_ctl,
    input  logic [7:0]        i_byte,
    output logic [3:0]        o_method_code,
    output logic [2:0]        o_version_code
);
    import hrp_pkg::*;

    logic [7:0] r_mcand, n_mcand;
    logic [3:0] r_mlen,  n_mlen;
    logic [3:0] r_vcand, n_vcand;
    logic [3:0] r_vlen,  n_vlen;
    logic [5:0] mbase;
    logic [5:0] vbase;

    // Character position inside the left-justified name word
    assign mbase = {~r_mlen[2:0], 3'b000};
    assign vbase = {~r_vlen[2:0], 3'b000};

    always_comb begin
        n_mcand = r_mcand;
        n_mlen  = r_mlen;
        n_vcand = r_vcand;
        n_vlen  = r_vlen;
        if (i_ctl.feed_method) begin
            for (int i = 0; i < NUM_METHODS; i++) begin
                if (r_mlen >= METHOD_LEN[i] || METHOD_NAME[i][mbase +: 8] != i_byte) begin
                    n_mcand[i] = 1'b0;
                end
            end
            if (r_mlen != TOKEN_MAX) begin
                n_mlen = r_mlen + 4'd1;
            end
        end
        if (i_ctl.feed_version) begin
            for (int i = 0; i < NUM_VERSIONS; i++) begin
                if (r_vlen >= VERSION_LEN || VERSION_NAME[i][vbase +: 8] != i_byte) begin
                    n_vcand[i] = 1'b0;
                end
            end
            if (r_vlen != TOKEN_MAX) begin
                n_vlen = r_vlen + 4'd1;
            end
        end
    end

    // Report from the updated token so a byte fed on the last transfer counts
    always_comb begin
        o_method_code = MC_UNKNOWN;
        for (int i = NUM_METHODS - 1; i >= 0; i--) begin
            if (n_mcand[i] && n_mlen == METHOD_LEN[i]) begin
                o_method_code = 4'(i);
            end
        end
        o_version_code = VC_UNKNOWN;
        for (int i = NUM_VERSIONS - 1; i >= 0; i--) begin
            if (n_vcand[i] && n_vlen == VERSION_LEN) begin
                o_version_code = 3'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctl.step && i_ctl.clear)) begin
            r_mcand <= '1;
            r_mlen  <= '0;
            r_vcand <= '1;
            r_vlen  <= '0;
        end else if (i_ctl.step) begin
            r_mcand <= n_mcand;
            r_mlen  <= n_mlen;
            r_vcand <= n_vcand;
            r_vlen  <= n_vlen;
        end
    end

endmodule

@@ rtl/core/hrp_phase_fsm.sv @@
// Phase sequencer: tags each byte, tracks the request line and header lines.
// Depends on hrp_pkg; drives the token matchers through a feed control struct.
module hrp_phase_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  hrp_pkg::t_in_item  i_item,
    input  logic [3:0]         i_method_code,
    input  logic [2:0]         i_version_code,
    output hrp_pkg::t_feed_ctl o_ctl,
    output hrp_pkg::t_out_item o_result
);
    import hrp_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_err,   n_err;
    logic [2:0] cls;
    logic       mvalid, vvalid, pend, hdone;
    logic       feed_m, feed_v;
    logic       is_sp, is_cr, is_colon;

    assign is_sp    = (i_item.byte_in == CH_SP);
    assign is_cr    = (i_item.byte_in == CH_CR);
    assign is_colon = (i_item.byte_in == CH_COLON);

    always_comb begin
        cls     = CL_DELIM;
        n_phase = r_phase;
        n_err   = r_err;
        mvalid  = 1'b0;
        vvalid  = 1'b0;
        pend    = 1'b0;
        hdone   = 1'b0;
        feed_m  = 1'b0;
        feed_v  = 1'b0;
        case (r_phase)
            PH_METHOD: begin
                if (is_sp) begin
                    mvalid  = 1'b1;
                    n_phase = PH_URI_GAP;
                end else begin
                    cls    = CL_METHOD;
                    feed_m = 1'b1;
                end
            end
            PH_URI_GAP: begin
                if (!is_sp) begin
                    cls     = CL_URI;
                    n_phase = PH_URI;
                end
            end
            PH_URI: begin
                if (is_sp) n_phase = PH_VER_GAP;
                else cls = CL_URI;
            end
            PH_VER_GAP, PH_VER: begin
                // skip the run of spaces before the version token
                if (!(r_phase == PH_VER_GAP && is_sp)) begin
                    if (is_cr) begin
                        vvalid  = 1'b1;
                        n_phase = PH_VER_LF;
                    end else begin
                        cls     = CL_VERSION;
                        feed_v  = 1'b1;
                        n_phase = PH_VER;
                    end
                end
            end
            PH_VER_LF: n_phase = PH_LINE;
            PH_LINE: begin
                if (is_cr) begin
                    hdone   = 1'b1;
                    n_phase = PH_END_LF;
                end else if (is_colon) begin
                    n_phase = PH_VAL_GAP;
                end else begin
                    cls     = CL_NAME;
                    n_phase = PH_NAME;
                end
            end
            PH_NAME: begin
                if (is_colon) begin
                    n_phase = PH_VAL_GAP;
                end else if (is_cr) begin
                    n_err   = 1'b1;
                    n_phase = PH_LINE_LF;
                end else begin
                    cls = CL_NAME;
                end
            end
            PH_VAL_GAP, PH_VAL: begin
                if (!(r_phase == PH_VAL_GAP && is_sp)) begin
                    if (is_cr) begin
                        pend    = 1'b1;
                        n_phase = PH_LINE_LF;
                    end else begin
                        cls     = CL_VALUE;
                        n_phase = PH_VAL;
                    end
                end
            end
            PH_LINE_LF: n_phase = PH_LINE;
            PH_END_LF:  n_phase = PH_BODY;
            PH_BODY:    cls = CL_BODY;
            default:    cls = CL_BODY;
        endcase

        // Close whatever is still open at the end of the message
        if (i_item.last) begin
            if (n_phase == PH_METHOD) mvalid = 1'b1;
            if (n_phase == PH_METHOD || n_phase == PH_URI_GAP || n_phase == PH_URI ||
                n_phase == PH_VER_GAP || n_phase == PH_VER) begin
                vvalid = 1'b1;
            end
            if (n_phase == PH_VAL_GAP || n_phase == PH_VAL) pend = 1'b1;
            if (n_phase == PH_NAME) n_err = 1'b1;
        end
    end

    assign o_ctl.step         = i_step;
    assign o_ctl.feed_method  = feed_m;
    assign o_ctl.feed_version = feed_v;
    assign o_ctl.clear        = i_item.last;

    assign o_result.byte_out      = i_item.byte_in;
    assign o_result.byte_class    = cls;
    assign o_result.method_code   = mvalid ? i_method_code : 4'd0;
    assign o_result.method_valid  = mvalid;
    assign o_result.version_code  = vvalid ? i_version_code : 3'd0;
    assign o_result.version_valid = vvalid;
    assign o_result.pair_end      = pend;
    assign o_result.header_error  = n_err;
    assign o_result.headers_done  = hdone;
    assign o_result.last_out      = i_item.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_item.last)) begin
            r_phase <= PH_METHOD;
            r_err   <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_err   <= n_err;
        end
    end

endmodule

@@ rtl/core/http_request_header_parser_unit.sv @@
// Top level of the HTTP request header parser: input register, parser core,
// result register. Depends on hrp_pkg, hrp_token_match and hrp_phase_fsm.

// Accepts one request byte per clock while the output is not stalled, and
// returns one tagged result per byte, in order, through the input register and
// the result register. The sustained rate is one byte per cycle while the
// output is not stalled; the parse phase and token candidate masks update
// between those registers. A stall on the output is absorbed by the result
// register, and the input register keeps accepting while it has room. The
// last flag ends a message: codes not yet given are reported on that byte and
// all parse state returns to its reset value for the next message.
module http_request_header_parser_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  hrp_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output hrp_pkg::t_out_item o_out,
    input  logic               i_out_stall
);
    import hrp_pkg::*;

    logic      r_s1_valid;
    t_in_item  r_s1;
    logic      r_out_valid;
    t_out_item r_out;
    logic      out_ready;
    logic      step;
    logic      in_xfer;
    t_feed_ctl ctl;
    t_out_item result;
    logic [3:0] method_code;
    logic [2:0] version_code;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign step       = r_s1_valid && out_ready;
    assign o_in_stall = r_s1_valid && !out_ready;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (step) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_s1 <= i_in;
    end

    hrp_phase_fsm u_fsm (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (step),
        .i_item         (r_s1),
        .i_method_code  (method_code),
        .i_version_code (version_code),
        .o_ctl          (ctl),
        .o_result       (result)
    );

    hrp_token_match u_match (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_byte         (r_s1.byte_in),
        .o_method_code  (method_code),
        .o_version_code (version_code)
    );

    // Hold the result while the downstream side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) r_out <= result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    a_method_end_on_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.method_valid && !o_out.last_out |-> o_out.byte_out == CH_SP)
        else $error("method end reported on a byte other than a space");

    a_version_end_on_cr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.version_valid && !o_out.last_out |-> o_out.byte_out == CH_CR)
        else $error("version end reported on a byte other than CR");

    a_headers_done_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.headers_done |->
            o_out.byte_out == CH_CR && o_out.byte_class == CL_DELIM)
        else $error("headers done not on a delimiter CR");

    a_body_no_tokens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.byte_class == CL_BODY |->
            !o_out.method_valid && !o_out.version_valid && !o_out.pair_end)
        else $error("token completion reported inside the body");

    a_step_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_valid)
        else $error("advanced item did not reach the result register");
`endif

endmodule
